/* rtl/core/fjps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fjps_pkg;

    // scan modes, stopped modes hold the error that stopped the scan
    typedef enum logic [3:0] {
        MODE_START_OBJ   = 4'd0,
        MODE_END_OBJ     = 4'd1,
        MODE_START_PROP  = 4'd2,
        MODE_END_PROP    = 4'd3,
        MODE_END_JSON    = 4'd4,
        MODE_KEY_Q       = 4'd5,
        MODE_VAL_Q       = 4'd6,
        MODE_KVP_SEP     = 4'd7,
        MODE_START_VAL   = 4'd8,
        MODE_VAL_ACC     = 4'd9,
        MODE_STOP_OPEN   = 4'd10,
        MODE_STOP_CLOSE  = 4'd11,
        MODE_STOP_QUOTE  = 4'd12,
        MODE_STOP_COLON  = 4'd13
    } scan_mode_t;

    typedef enum logic [2:0] {
        STATUS_RUN         = 3'd0,
        STATUS_GOOD        = 3'd1,
        STATUS_NO_ROOT     = 3'd2,
        STATUS_STRAY_OPEN  = 3'd3,
        STATUS_STRAY_CLOSE = 3'd4,
        STATUS_STRAY_QUOTE = 3'd5,
        STATUS_STRAY_COLON = 3'd6,
        STATUS_UNKNOWN     = 3'd7
    } scan_status_t;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_KEY   = 2'd1,
        ROLE_VALUE = 2'd2
    } byte_role_t;

    typedef struct packed {
        byte_role_t   role;
        logic         pair_done;
        scan_status_t status;
    } step_result_t;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

endpackage

`default_nettype wire

/* rtl/core/fjps_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// input channel: one text byte per word
interface fjps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// output channel: one tagged byte per word
interface fjps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [1:0] byte_role;
    logic       pair_done;
    logic [2:0] scan_status;
    logic       message_end;

    modport source (output valid, output byte_out, output byte_role, output pair_done,
                    output scan_status, output message_end, input ready);
    modport sink (input valid, input byte_out, input byte_role, input pair_done,
                  input scan_status, input message_end, output ready);
endinterface

`default_nettype wire

/* rtl/core/fjps_step.sv */
`timescale 1ns / 1ps
`default_nettype none

module fjps_step (
    input  fjps_pkg::scan_mode_t   mode,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output fjps_pkg::step_result_t result,
    output fjps_pkg::scan_mode_t   mode_next
);
    import fjps_pkg::*;

    scan_mode_t   m;
    scan_status_t err;
    logic         err_flag;
    logic         stopped;
    logic         quoted;
    logic         is_space;

    always_comb
    begin
        stopped  = (mode == MODE_STOP_OPEN) || (mode == MODE_STOP_CLOSE) ||
                   (mode == MODE_STOP_QUOTE) || (mode == MODE_STOP_COLON);
        quoted   = (mode == MODE_KEY_Q) || (mode == MODE_VAL_Q);
        is_space = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB) ||
                   (data_byte == CHAR_LF) || (data_byte == CHAR_CR);
        m        = mode;
        err      = STATUS_RUN;
        err_flag = 1'b0;
        result   = '{role: ROLE_NONE, pair_done: 1'b0, status: STATUS_RUN};

        priority if (stopped)
        begin
            if (last_byte)
            begin
                unique case (mode)
                    MODE_STOP_OPEN:  result.status = STATUS_STRAY_OPEN;
                    MODE_STOP_CLOSE: result.status = STATUS_STRAY_CLOSE;
                    MODE_STOP_QUOTE: result.status = STATUS_STRAY_QUOTE;
                    default:         result.status = STATUS_STRAY_COLON;
                endcase
            end
        end
        else if (quoted && data_byte != CHAR_QUOTE)
        begin
            result.role = (mode == MODE_KEY_Q) ? ROLE_KEY : ROLE_VALUE;
        end
        else if (is_space)
        begin
            if (mode == MODE_VAL_ACC)
            begin
                result.pair_done = 1'b1;
                m = MODE_END_PROP;
            end
        end
        else if (data_byte == CHAR_OPEN)
        begin
            if (mode == MODE_START_OBJ)
                m = MODE_START_PROP;
            else
                err_flag = 1'b1;
            err = STATUS_STRAY_OPEN;
        end
        else if (data_byte == CHAR_CLOSE)
        begin
            // an unquoted value closes its pair before the brace ends the object
            if (mode == MODE_VAL_ACC)
                result.pair_done = 1'b1;
            if (mode == MODE_VAL_ACC || mode == MODE_START_PROP || mode == MODE_END_PROP)
                m = MODE_END_JSON;
            else
                err_flag = 1'b1;
            err = STATUS_STRAY_CLOSE;
        end
        else if (data_byte == CHAR_QUOTE)
        begin
            err = STATUS_STRAY_QUOTE;
            priority case (mode)
                MODE_START_PROP: m = MODE_KEY_Q;
                MODE_KEY_Q:      m = MODE_KVP_SEP;
                MODE_START_VAL:  m = MODE_VAL_Q;
                MODE_VAL_Q:
                begin
                    result.pair_done = 1'b1;
                    m = MODE_END_PROP;
                end
                default:         err_flag = 1'b1;
            endcase
        end
        else if (data_byte == CHAR_COMMA)
        begin
            if (mode == MODE_VAL_ACC)
                result.pair_done = 1'b1;
            if (mode == MODE_VAL_ACC || mode == MODE_END_PROP)
                m = MODE_START_PROP;
        end
        else if (data_byte == CHAR_COLON)
        begin
            if (mode == MODE_KVP_SEP)
                m = MODE_START_VAL;
            else
                err_flag = 1'b1;
            err = STATUS_STRAY_COLON;
        end
        else
        begin
            if (mode == MODE_START_VAL)
            begin
                result.role = ROLE_VALUE;
                m = MODE_VAL_ACC;
            end
            else if (mode == MODE_VAL_ACC)
            begin
                result.role = ROLE_VALUE;
            end
        end

        if (err_flag)
        begin
            result.role      = ROLE_NONE;
            result.pair_done = 1'b0;
            result.status    = err;
            unique case (err)
                STATUS_STRAY_OPEN:  m = MODE_STOP_OPEN;
                STATUS_STRAY_CLOSE: m = MODE_STOP_CLOSE;
                STATUS_STRAY_QUOTE: m = MODE_STOP_QUOTE;
                default:            m = MODE_STOP_COLON;
            endcase
        end
        else if (last_byte && !stopped)
        begin
            if (m == MODE_END_JSON)
                result.status = STATUS_GOOD;
            else if (m == MODE_START_OBJ)
                result.status = STATUS_NO_ROOT;
            else
                result.status = STATUS_UNKNOWN;
        end

        mode_next = last_byte ? MODE_START_OBJ : m;
    end

endmodule

`default_nettype wire

/* rtl/core/flat_json_pair_scanner.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    modport  word
// scan_in    sink     data_byte[7:0], last_byte
// scan_out   source   byte_out[7:0], byte_role[1:0], pair_done, scan_status[2:0],
//                     message_end
//
// one byte per cycle sustained while scan_out is ready; a byte taken passes through
// the input register, then the result register behind the step logic
// the scan mode register is the only loop
// rst_n clears the scan mode to start-of-object and empties both registers
// a stall on scan_out fills the input register, then drops scan_in.ready

module flat_json_pair_scanner (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fjps_in_if.sink     scan_in,
    fjps_out_if.source  scan_out
);
    import fjps_pkg::*;

    // input register
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;

    // scan state
    scan_mode_t   mode_reg;
    scan_mode_t   mode_next;
    step_result_t step_res;

    // result register
    logic         out_valid_reg;
    logic         out_valid_next;
    logic [7:0]   out_byte_reg;
    step_result_t out_res_reg;
    logic         out_end_reg;

    logic         in_take;
    logic         step_go;
    logic         in_valid_next;

    // the input byte moves on whenever the result register is empty or draining
    assign step_go        = in_valid_reg && (!out_valid_reg || scan_out.ready);
    assign scan_in.ready  = !in_valid_reg || step_go;
    assign in_take        = scan_in.valid && scan_in.ready;
    assign in_valid_next  = in_take || (in_valid_reg && !step_go);
    assign out_valid_next = step_go || (out_valid_reg && !scan_out.ready);

    fjps_step u_step (
        .mode      (mode_reg),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (step_res),
        .mode_next (mode_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_START_OBJ;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_go)
                mode_reg <= mode_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= scan_in.data_byte;
            in_last_reg <= scan_in.last_byte;
        end
        if (step_go)
        begin
            out_byte_reg <= in_byte_reg;
            out_res_reg  <= step_res;
            out_end_reg  <= in_last_reg;
        end
    end

    assign scan_out.valid       = out_valid_reg;
    assign scan_out.byte_out    = out_byte_reg;
    assign scan_out.byte_role   = out_res_reg.role;
    assign scan_out.pair_done   = out_res_reg.pair_done;
    assign scan_out.scan_status = out_res_reg.status;
    assign scan_out.message_end = out_end_reg;

`ifndef SYNTHESIS
    // the scan restarts after the final byte of a message
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && in_last_reg |=> mode_reg == MODE_START_OBJ)
        else $error("scan mode not cleared after final byte");

    // a processed byte always lands in the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        step_go |=> out_valid_reg)
        else $error("result register empty after step");

    // error words carry no role and no pair mark
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.status == STATUS_STRAY_OPEN ||
        out_res_reg.status == STATUS_STRAY_CLOSE ||
        out_res_reg.status == STATUS_STRAY_QUOTE ||
        out_res_reg.status == STATUS_STRAY_COLON)
        |-> out_res_reg.role == ROLE_NONE && !out_res_reg.pair_done)
        else $error("error word tagged as content");

    // before the final byte only errors may show a status
    a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_end_reg |-> out_res_reg.status == STATUS_RUN ||
        out_res_reg.status == STATUS_STRAY_OPEN ||
        out_res_reg.status == STATUS_STRAY_CLOSE ||
        out_res_reg.status == STATUS_STRAY_QUOTE ||
        out_res_reg.status == STATUS_STRAY_COLON)
        else $error("final status before message end");
`endif

endmodule

`default_nettype wire
